// ----- rtl/uab_pkg.sv -----
// Shared types, constants and status function for the UART autobaud detector.
package uab_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 16;
	localparam int unsigned FIELD_W         = 16;
	localparam int unsigned UNIT_SHIFT      = 4;
	localparam int unsigned CFG_W           = 8;
	localparam int unsigned REG_IDX_W       = 1;

	localparam logic [CFG_W-1:0]   ATTEMPT_LIMIT_RST = 8'd200;
	localparam logic [CFG_W-1:0]   MIN_CAPTURES_RST  = 8'd3;
	localparam logic [CFG_W-1:0]   CAP_MAX           = 8'd255;
	localparam logic [FIELD_W-1:0] SHORT_NONE        = 16'hFFFF;
	localparam logic [2:0]         END_RATIO         = 3'd5;

	localparam logic [REG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_CAPTURES  = 1'd1;

	typedef enum logic [1:0] {
		CMD_START    = 2'd0,
		CMD_CAPTURE  = 2'd1,
		CMD_SKIP     = 2'd2,
		CMD_OVERFLOW = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_RUNNING = 2'd0,
		ST_SUCCESS = 2'd1,
		ST_TOO_LOW = 2'd2,
		ST_FEW     = 2'd3
	} stat_t;

	function automatic stat_t end_status(input logic [FIELD_W-1:0] shortest,
			input logic [CFG_W-1:0] captures, input logic [CFG_W-1:0] min_caps);
		stat_t s;
		if (shortest[FIELD_W-1:8] != '0) begin
			s = ST_TOO_LOW;
		end else if (captures < min_caps) begin
			s = ST_FEW;
		end else begin
			s = ST_SUCCESS;
		end
		return s;
	endfunction

endpackage

// ----- rtl/uart_autobaud_detector.sv -----
// Top level of the UART autobaud detector: run state update and result register.
// A result appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless stalled; the state update is a single
// registered pass (round, compare, subtract, times-five check) between state and result registers.
// Reset: asynchronous, clears the run to a fresh running state and loads the
// register defaults (attempt limit 200, minimum captures 3).
module uart_autobaud_detector
	import uab_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [FIELD_W-1:0]   interval,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 done_res,
	output logic [1:0]           status,
	output logic [7:0]           reload,
	output logic [FIELD_W-1:0]   shortest_unit
);

	localparam int unsigned TAKE_W = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;
	localparam int unsigned UNIT_W = TAKE_W + 1 - UNIT_SHIFT;
	localparam int unsigned PROD_W = FIELD_W + 3;
	localparam logic [FIELD_W-1:0] UNIT_MAX = FIELD_W'({UNIT_W{1'b1}});

	logic [CFG_W-1:0]   attempt_limit_q, min_captures_q;
	logic [CFG_W-1:0]   att_q, att_d, att_inc;
	logic [CFG_W-1:0]   cap_q, cap_d, cap_inc;
	logic [UNIT_W-1:0]  long_q, long_d, long_c;
	logic [FIELD_W-1:0] short_q, short_d, short_c;
	logic               fin_q, fin_d;
	stat_t              stat_q, stat_d;
	logic               out_valid_q;
	logic               in_acc;
	cmd_t               cmd;

	logic [TAKE_W:0]    rounded;
	logic [UNIT_W-1:0]  unit, unit_r;
	logic [FIELD_W-1:0] unit16, unit_r16;
	logic               reduce, success;
	logic [PROD_W-1:0]  short_x5;

	assign in_stall  = out_valid_q && out_stall;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign cmd       = cmd_t'(command);

	assign rounded  = {1'b0, interval[TAKE_W-1:0]} + (TAKE_W+1)'(8);
	assign unit     = rounded[TAKE_W:UNIT_SHIFT];
	assign unit16   = FIELD_W'(unit);
	assign long_c   = (unit > long_q) ? unit : long_q;
	assign reduce   = ({1'b0, unit16} > {1'b0, short_q}) && ({1'b0, unit16} < {short_q, 1'b0});
	assign unit_r   = reduce ? UNIT_W'(unit16 - short_q) : unit;
	assign unit_r16 = FIELD_W'(unit_r);
	assign short_c  = (unit_r16 < short_q) ? unit_r16 : short_q;
	assign short_x5 = PROD_W'(short_c) * PROD_W'(END_RATIO);
	assign success  = PROD_W'(long_c) >= short_x5;
	assign cap_inc  = (cap_q == CAP_MAX) ? cap_q : cap_q + 8'd1;
	assign att_inc  = att_q + 8'd1;

	always_comb begin
		att_d   = att_q;
		cap_d   = cap_q;
		long_d  = long_q;
		short_d = short_q;
		fin_d   = fin_q;
		stat_d  = stat_q;
		if (in_acc) begin
			unique case (cmd)
				CMD_START: begin
					att_d   = '0;
					cap_d   = '0;
					long_d  = '0;
					short_d = SHORT_NONE;
					fin_d   = 1'b0;
					stat_d  = ST_RUNNING;
					if (attempt_limit_q == '0) begin
						fin_d  = 1'b1;
						stat_d = end_status(SHORT_NONE, '0, min_captures_q);
					end
				end
				CMD_CAPTURE: begin
					if (!fin_q) begin
						cap_d   = cap_inc;
						long_d  = long_c;
						short_d = short_c;
						if (success) begin
							cap_d  = CAP_MAX;
							fin_d  = 1'b1;
							stat_d = end_status(short_c, CAP_MAX, min_captures_q);
						end else begin
							att_d = att_inc;
							if (att_inc >= attempt_limit_q) begin
								fin_d  = 1'b1;
								stat_d = end_status(short_c, cap_inc, min_captures_q);
							end
						end
					end
				end
				CMD_SKIP: begin
					if (!fin_q) begin
						att_d = att_inc;
						if (att_inc >= attempt_limit_q) begin
							fin_d  = 1'b1;
							stat_d = end_status(short_q, cap_q, min_captures_q);
						end
					end
				end
				CMD_OVERFLOW: begin
					if (!fin_q) begin
						fin_d  = 1'b1;
						stat_d = ST_TOO_LOW;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= ATTEMPT_LIMIT_RST;
			min_captures_q  <= MIN_CAPTURES_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data;
				REG_MIN_CAPTURES:  min_captures_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q       <= '0;
			cap_q       <= '0;
			long_q      <= '0;
			short_q     <= SHORT_NONE;
			fin_q       <= 1'b0;
			stat_q      <= ST_RUNNING;
			out_valid_q <= 1'b0;
		end else begin
			att_q   <= att_d;
			cap_q   <= cap_d;
			long_q  <= long_d;
			short_q <= short_d;
			fin_q   <= fin_d;
			stat_q  <= stat_d;
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			done_res      <= fin_d;
			status        <= stat_d;
			reload        <= 8'(8'd0 - short_d[7:0]);
			shortest_unit <= short_d;
		end
	end

	a_fin_status: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q == (stat_q != ST_RUNNING))
		else $error("finished flag and final status disagree");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted word produced no result");

	a_short_range: assert property (@(posedge clk) disable iff (!arst_n)
		(short_q == SHORT_NONE) || (short_q <= UNIT_MAX))
		else $error("shortest unit out of range");

	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (done_res == fin_q) && (shortest_unit == short_q))
		else $error("result register does not match run state");

endmodule
